/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the axis PID PWM controller.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define AXP_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define AXP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define AXP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/axpid_pkg.sv */
// Package of the axis PID PWM controller: constants, direction codes and stage types.
// No dependencies.
`timescale 1ns / 1ps

package axpid_pkg;

  // Direction codes of move_dir; codes above DirDown mean no move.
  localparam logic [2:0] DirNone  = 3'd0;
  localparam logic [2:0] DirRight = 3'd1;
  localparam logic [2:0] DirLeft  = 3'd2;
  localparam logic [2:0] DirUp    = 3'd3;
  localparam logic [2:0] DirDown  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] RegGainP = 2'd0;
  localparam logic [1:0] RegGainI = 2'd1;
  localparam logic [1:0] RegGainD = 2'd2;

  localparam logic [11:0] ErrSumLimit = 12'd3000;
  localparam logic signed [9:0] DerrPos   = 10'sd300;
  localparam logic signed [9:0] DerrNeg   = -10'sd300;
  localparam logic signed [9:0] DerrStepP = 10'sd200;
  localparam logic signed [9:0] DerrStepN = -10'sd200;

  localparam logic [7:0] PwmFloorNear = 8'd135;
  localparam logic [7:0] PwmFloorFar  = 8'd140;
  localparam logic [7:0] PwmCeilNear  = 8'd160;
  localparam logic [7:0] PwmCeilFar   = 8'd200;

  localparam int SumW = 30;

  // One accepted control tick.
  typedef struct packed {
    logic [2:0]        move_dir;
    logic signed [9:0] target_horiz;
    logic signed [9:0] measured_horiz;
    logic signed [9:0] target_vert;
    logic signed [9:0] measured_vert;
    logic [31:0]       now_ms;
    logic [31:0]       move_begin_ms;
  } tick_t;

  // Multiplier operands after the state update.
  typedef struct packed {
    logic              quiet;
    logic              near;
    logic [9:0]        err;
    logic [11:0]       integ;
    logic signed [9:0] derr;
  } ops_t;

  // Registered products.
  typedef struct packed {
    logic                   quiet;
    logic                   near;
    logic signed [SumW-1:0] prod_p;
    logic signed [SumW-1:0] prod_i;
    logic signed [SumW-1:0] prod_d;
  } prod_t;

endpackage

/* rtl/core/axis_pid_pwm_controller.sv */
// Axis PID controller with clamped PWM duty output.
// A word passes the input register, the operand and product registers and the output register.
// Throughput: one word per cycle while out_stall is low; the integral, previous error,
// direction and settle time update as a word leaves the input register.
// Reset (synchronous, active high) clears the gains, the controller state and
// empties the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module axis_pid_pwm_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        move_dir,
  input  logic signed [9:0] target_horiz,
  input  logic signed [9:0] measured_horiz,
  input  logic signed [9:0] target_vert,
  input  logic signed [9:0] measured_vert,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       move_begin_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        pwm_duty
);

  logic signed [15:0] gain_proportional;
  logic signed [15:0] gain_integral;
  logic signed [15:0] gain_derivative;

  logic [31:0] settle_time, settle_time_next;
  logic [11:0] integral_sum, integral_sum_next;
  logic [9:0]  previous_error, previous_error_next;
  logic [2:0]  previous_dir;

  axpid_pkg::tick_t s0;
  axpid_pkg::ops_t  s1, s1_next;
  axpid_pkg::prod_t s2, s2_next;
  logic s0_valid, s1_valid, s2_valid;
  logic s0_adv, s1_adv, s2_adv;
  logic out_free, s2_free, s1_free, s0_free;
  logic [7:0] duty_next;

  // Each stage moves on when the one after it is empty or moving too.
  assign out_free = !out_valid || !out_stall;
  assign s2_adv   = s2_valid && out_free;
  assign s2_free  = !s2_valid || out_free;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s0_adv   = s0_valid && s1_free;
  assign s0_free  = !s0_valid || s1_free;
  assign in_stall = !s0_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        axpid_pkg::RegGainP: gain_proportional <= cfg_data;
        axpid_pkg::RegGainI: gain_integral     <= cfg_data;
        axpid_pkg::RegGainD: gain_derivative   <= cfg_data;
        default: ;
      endcase
    end
  end

  // State update and operand preparation for the word in the input register.
  logic              new_move, dir_change, is_horiz, is_vert, idle, settle_hit;
  logic [31:0]       settle_mid;
  logic [11:0]       integ_mid;
  logic [9:0]        perr_mid;
  logic signed [10:0] diff, diff_abs, err_step;
  logic [9:0]        err;
  logic [12:0]       isum;
  logic [11:0]       integ_new;
  logic signed [9:0] derr;

  always_comb begin
    new_move   = settle_time < s0.move_begin_ms;
    dir_change = previous_dir != s0.move_dir;
    settle_mid = new_move ? s0.move_begin_ms : settle_time;
    integ_mid  = (new_move || dir_change) ? '0 : integral_sum;
    perr_mid   = (new_move || dir_change) ? '0 : previous_error;

    is_horiz = (s0.move_dir == axpid_pkg::DirRight) || (s0.move_dir == axpid_pkg::DirLeft);
    is_vert  = (s0.move_dir == axpid_pkg::DirUp) || (s0.move_dir == axpid_pkg::DirDown);
    idle     = !(is_horiz || is_vert);

    if (is_horiz) begin
      diff = 11'(s0.target_horiz) - 11'(s0.measured_horiz);
    end else begin
      diff = 11'(s0.target_vert) - 11'(s0.measured_vert);
    end
    diff_abs = diff[10] ? -diff : diff;
    err      = diff_abs[9:0];

    settle_hit = !idle && ((err == '0) || (err <= 10'd1 && perr_mid > 10'd1));

    isum      = {1'b0, integ_mid} + 13'(err);
    integ_new = (isum > 13'(axpid_pkg::ErrSumLimit)) ? axpid_pkg::ErrSumLimit : isum[11:0];

    // 200 times the step, clamped to 300: any step of two or more saturates.
    err_step = $signed({1'b0, err}) - $signed({1'b0, perr_mid});
    if (err_step >= 11'sd2) begin
      derr = axpid_pkg::DerrPos;
    end else if (err_step <= -11'sd2) begin
      derr = axpid_pkg::DerrNeg;
    end else if (err_step == 11'sd1) begin
      derr = axpid_pkg::DerrStepP;
    end else if (err_step == -11'sd1) begin
      derr = axpid_pkg::DerrStepN;
    end else begin
      derr = '0;
    end

    settle_time_next    = settle_mid;
    integral_sum_next   = integ_mid;
    previous_error_next = perr_mid;
    if (settle_hit) begin
      settle_time_next    = s0.now_ms;
      integral_sum_next   = '0;
      previous_error_next = '0;
    end else if (!idle) begin
      integral_sum_next   = integ_new;
      previous_error_next = err;
    end

    s1_next.quiet = idle || settle_hit;
    s1_next.near  = err <= 10'd2;
    s1_next.err   = err;
    s1_next.integ = integ_new;
    s1_next.derr  = derr;
  end

  // Three products in parallel.
  always_comb begin
    s2_next.quiet  = s1.quiet;
    s2_next.near   = s1.near;
    s2_next.prod_p = axpid_pkg::SumW'(gain_proportional) * axpid_pkg::SumW'($signed({1'b0, s1.err}));
    s2_next.prod_i = axpid_pkg::SumW'(gain_integral) * axpid_pkg::SumW'($signed({1'b0, s1.integ}));
    s2_next.prod_d = axpid_pkg::SumW'(gain_derivative) * axpid_pkg::SumW'(s1.derr);
  end

  // Sum, truncate to an integer, saturate to 0..255, then floor and ceiling.
  logic signed [axpid_pkg::SumW-1:0] sum;
  logic [7:0] trunc, floor_pwm, ceil_pwm;
  logic [8:0] duty_raw;

  always_comb begin
    sum = s2.prod_p + s2.prod_i + s2.prod_d;
    if (sum <= 0) begin
      trunc = '0;
    end else if (|sum[axpid_pkg::SumW-1:16]) begin
      trunc = 8'hFF;
    end else begin
      trunc = sum[15:8];
    end
    floor_pwm = s2.near ? axpid_pkg::PwmFloorNear : axpid_pkg::PwmFloorFar;
    ceil_pwm  = s2.near ? axpid_pkg::PwmCeilNear : axpid_pkg::PwmCeilFar;
    duty_raw  = 9'(floor_pwm) + 9'(trunc);
    if (s2.quiet) begin
      duty_next = '0;
    end else if (duty_raw > 9'(ceil_pwm)) begin
      duty_next = ceil_pwm;
    end else begin
      duty_next = duty_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      settle_time    <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
      previous_dir   <= axpid_pkg::DirNone;
    end else begin
      if (s0_free) begin
        s0_valid <= in_valid;
      end
      if (s1_free) begin
        s1_valid <= s0_adv;
      end
      if (s2_free) begin
        s2_valid <= s1_adv;
      end
      if (out_free) begin
        out_valid <= s2_adv;
      end
      if (s0_adv) begin
        settle_time    <= settle_time_next;
        integral_sum   <= integral_sum_next;
        previous_error <= previous_error_next;
        previous_dir   <= s0.move_dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      s0.move_dir       <= move_dir;
      s0.target_horiz   <= target_horiz;
      s0.measured_horiz <= measured_horiz;
      s0.target_vert    <= target_vert;
      s0.measured_vert  <= measured_vert;
      s0.now_ms         <= now_ms;
      s0.move_begin_ms  <= move_begin_ms;
    end
    if (s0_adv) begin
      s1 <= s1_next;
    end
    if (s1_adv) begin
      s2 <= s2_next;
    end
    if (s2_adv) begin
      pwm_duty <= duty_next;
    end
  end

  `AXP_ASSERT_HOLDS(a_integral_limit, clk, rst, integral_sum <= axpid_pkg::ErrSumLimit, "integral above its limit")
  `AXP_ASSERT_IMPLIES(a_duty_range, clk, rst, out_valid, pwm_duty == 8'd0 || (pwm_duty >= axpid_pkg::PwmFloorNear && pwm_duty <= axpid_pkg::PwmCeilFar), "duty outside its range")
  `AXP_ASSERT_NEXT(a_settle_clears, clk, rst, s0_adv && settle_hit, integral_sum == '0 && previous_error == '0, "settle did not clear the state")

endmodule

/* verif/pwm_duty_monitor.sv */
// Monitor for the axis PID PWM controller test: watches the gain writes and both word
// channels, predicts every duty and compares it with the block's result words.
// Depends on axpid_pkg for the tick word type, direction codes and PWM limits.
`timescale 1ns / 1ps

module pwm_duty_monitor
  import axpid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        move_dir,
  input  logic signed [9:0] target_horiz,
  input  logic signed [9:0] measured_horiz,
  input  logic signed [9:0] target_vert,
  input  logic signed [9:0] measured_vert,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       move_begin_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        pwm_duty,
  output int                duty_mismatches,
  output int                pending_duties,
  output int                duties_compared,
  output int                active_duties
);

  localparam int ErrSumMax = 3000;
  localparam int DerrMax   = 300;
  localparam int DerrScale = 200;

  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [31:0]        settle_ms;
  int                 integ_acc;
  int                 last_err;
  logic [2:0]         last_dir;
  logic [7:0]         expected_duty[$];
  tick_t              in_word;

  assign in_word = {move_dir, target_horiz, measured_horiz, target_vert, measured_vert,
                    now_ms, move_begin_ms};

  // Advances the controller state by one tick and returns the duty it should give.
  function automatic logic [7:0] predict_duty(input tick_t w);
    int     tgt, meas, err, derr, floor_v, ceil_v, duty;
    longint total, lift;
    if (settle_ms < w.move_begin_ms) begin
      settle_ms = w.move_begin_ms;
      integ_acc = 0;
      last_err  = 0;
    end
    if (last_dir != w.move_dir) begin
      integ_acc = 0;
      last_err  = 0;
      last_dir  = w.move_dir;
    end
    if (w.move_dir == DirNone || w.move_dir > DirDown) return 8'd0;
    if (w.move_dir <= DirLeft) begin
      tgt  = $signed(w.target_horiz);
      meas = $signed(w.measured_horiz);
    end else begin
      tgt  = $signed(w.target_vert);
      meas = $signed(w.measured_vert);
    end
    err = tgt - meas;
    if (err < 0) err = -err;
    // On target, or dropping into the one-degree band from outside it, counts as settled.
    if (err == 0 || (err <= 1 && last_err > 1)) begin
      integ_acc = 0;
      last_err  = 0;
      settle_ms = w.now_ms;
      return 8'd0;
    end
    integ_acc = integ_acc + err;
    if (integ_acc > ErrSumMax) integ_acc = ErrSumMax;
    derr = DerrScale * (err - last_err);
    if (derr > DerrMax) derr = DerrMax;
    if (derr < -DerrMax) derr = -DerrMax;
    total = longint'(gain_p) * err + longint'(gain_i) * integ_acc + longint'(gain_d) * derr;
    if (total <= 0) begin
      lift = 0;
    end else begin
      lift = total / 256;
      if (lift > 255) lift = 255;
    end
    floor_v = (err <= 2) ? int'(PwmFloorNear) : int'(PwmFloorFar);
    ceil_v  = (err <= 2) ? int'(PwmCeilNear) : int'(PwmCeilFar);
    duty = floor_v + int'(lift);
    if (duty > ceil_v) duty = ceil_v;
    last_err = err;
    return duty[7:0];
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      settle_ms = '0;
      integ_acc = 0;
      last_err = 0;
      last_dir = DirNone;
      expected_duty.delete();
      duty_mismatches = 0;
      duties_compared = 0;
      active_duties = 0;
      pending_duties <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegGainP: gain_p = cfg_data;
          RegGainI: gain_i = cfg_data;
          RegGainD: gain_d = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_duty.push_back(predict_duty(in_word));
      if (out_valid && !out_stall) begin
        if (expected_duty.size() == 0) begin
          duty_mismatches++;
          if (duty_mismatches <= 10)
            $display("%0t: result word with no tick waiting: pwm_duty %0d", $realtime, pwm_duty);
        end else begin
          want = expected_duty.pop_front();
          duties_compared++;
          if (want != 0) active_duties++;
          if (pwm_duty !== want) begin
            duty_mismatches++;
            if (duty_mismatches <= 10)
              $display("%0t: pwm_duty mismatch on result %0d: expected %0d, got %0d",
                       $realtime, duties_compared, want, pwm_duty);
          end
        end
      end
      pending_duties <= expected_duty.size();
    end
  end

endmodule

/* verif/axis_pid_pwm_controller_test.sv */
// Top of the axis PID PWM controller test: clock, reset, gain writes and tick stimulus.
// Depends on axpid_pkg, the controller RTL and pwm_duty_monitor, which checks the duty words.
`timescale 1ns / 1ps

module axis_pid_pwm_controller_test;
  import axpid_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam logic [2:0] DirLast  = 3'd7;
  localparam int         NumPhases = 5;
  localparam int         TicksPerPhase = 216;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = RegGainP;
  logic [15:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        move_dir = DirNone;
  logic signed [9:0] target_horiz = '0;
  logic signed [9:0] measured_horiz = '0;
  logic signed [9:0] target_vert = '0;
  logic signed [9:0] measured_vert = '0;
  logic [31:0]       now_ms = '0;
  logic [31:0]       move_begin_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        pwm_duty;

  int duty_mismatches, pending_duties, duties_compared, active_duties;
  int idle_pct = 0;
  int stall_pct = 0;
  int ticks_sent = 0;

  axis_pid_pwm_controller i_dut (.*);
  pwm_duty_monitor i_mon (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic tick_t tick_of(input logic [2:0] dir, input int th, mh, tv, mv,
                                    input logic [31:0] now, beg);
    tick_t w;
    w.move_dir = dir;
    w.target_horiz = 10'(th);
    w.measured_horiz = 10'(mh);
    w.target_vert = 10'(tv);
    w.measured_vert = 10'(mv);
    w.now_ms = now;
    w.move_begin_ms = beg;
    return w;
  endfunction

  // The word is held until the block takes it; valid stays high into the next word
  // unless a gap is drawn.
  task automatic send_tick(input tick_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    move_dir <= w.move_dir;
    target_horiz <= w.target_horiz;
    measured_horiz <= w.measured_horiz;
    target_vert <= w.target_vert;
    measured_vert <= w.measured_vert;
    now_ms <= w.now_ms;
    move_begin_ms <= w.move_begin_ms;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Gains change only with the pipeline empty.
  task automatic set_gains(input logic [15:0] p, i, d, input bit poke_spare);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_duties != 0);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= RegGainP;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= RegGainI;
    cfg_data <= i;
    @(posedge clk);
    cfg_index <= RegGainD;
    cfg_data <= d;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= RegSpare;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          phase_idle[NumPhases] = '{0, 55, 0, 33, 0};
    int          phase_stall[NumPhases] = '{0, 0, 55, 33, 0};
    logic [2:0]  mv_dir, odd_dir;
    int          mv_tgt, mv_meas, gap, roll, ticks_left;
    logic [31:0] ms, mv_begin;
    tick_t       w;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks with moderate gains: Kp 1.5, Ki 1/16, Kd 1/4.
    set_gains(16'h0180, 16'h0010, 16'h0040, 1'b0);
    send_tick(tick_of(DirNone, 0, 0, 0, 0, 10, 0));
    send_tick(tick_of(DirRight, 20, 20, -100, 300, 12, 5));
    send_tick(tick_of(DirRight, 511, -512, 0, 0, 14, 13));
    send_tick(tick_of(DirRight, 511, -512, 0, 0, 16, 13));
    send_tick(tick_of(DirRight, 511, -512, 0, 0, 18, 13));
    send_tick(tick_of(DirRight, 100, 90, 0, 0, 20, 13));
    send_tick(tick_of(DirRight, 100, 98, 0, 0, 22, 13));
    send_tick(tick_of(DirRight, 100, 99, 0, 0, 24, 13));
    send_tick(tick_of(DirLeft, -512, 511, 5, 5, 26, 13));
    send_tick(tick_of(DirLeft, 5, 4, 0, 0, 28, 13));
    send_tick(tick_of(DirLeft, 5, 4, 0, 0, 30, 13));
    send_tick(tick_of(DirUp, 0, 300, -512, 511, 32, 31));
    send_tick(tick_of(DirDown, 0, 300, 7, 10, 34, 31));
    send_tick(tick_of(DirDown, 0, 300, 9, 10, 36, 31));
    for (int d = DirDown + 1; d <= DirLast; d++)
      send_tick(tick_of(3'(d), 50, -50, 50, -50, 38, 31));
    send_tick(tick_of(DirRight, 3, 3, 0, 0, 32'hFFFF_FFFF, 100));
    send_tick(tick_of(DirRight, 50, 0, 0, 0, 200, 150));
    send_tick(tick_of(DirRight, 50, 1, 0, 0, 210, 32'hFFFF_FFFF));
    // Settling at time zero brings the settle time back down for the random part.
    send_tick(tick_of(DirRight, 0, 0, 0, 0, 0, 0));

    ms = $urandom_range(1000, 100000);
    ticks_left = 0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: set_gains(16'($urandom_range(0, 16'h0600)), 16'($urandom_range(0, 16'h0040)),
                     16'($urandom_range(0, 16'h0200)), 1'b0);
        1: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        2: set_gains(16'h8000, 16'h8000, 16'h8000, 1'b1);
        3: set_gains(16'($urandom_range(0, 16'h0400)) - 16'h0200,
                     16'($urandom_range(0, 16'h0040)) - 16'h0020,
                     16'($urandom_range(0, 16'h0200)) - 16'h0100, 1'b0);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      endcase
      idle_pct = phase_idle[phase];
      stall_pct = phase_stall[phase];
      for (int n = 0; n < TicksPerPhase; n++) begin
        roll = $urandom_range(0, 99);
        if (ticks_left == 0 || roll < 3) begin
          mv_dir = 3'($urandom_range(DirRight, DirDown));
          mv_tgt = $urandom_range(0, 1023) - 512;
          mv_meas = $urandom_range(0, 1023) - 512;
          ticks_left = $urandom_range(2, 16);
          ms += $urandom_range(1, 40);
          mv_begin = ms;
        end
        ms += $urandom_range(1, 20);
        // The measured angle closes in on the target, landing on or next to it.
        gap = mv_tgt - mv_meas;
        if (gap > 2 || gap < -2) begin
          mv_meas += gap / 2 + int'($urandom_range(0, 2)) - 1;
        end else begin
          case ($urandom_range(0, 3))
            0: mv_meas = mv_tgt;
            1: mv_meas = mv_tgt + 1;
            2: mv_meas = mv_tgt - 1;
            default: ;
          endcase
        end
        if (mv_meas > 511) mv_meas = 511;
        if (mv_meas < -512) mv_meas = -512;

        w = tick_of(3'($urandom_range(0, DirLast)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        if (roll < 85) begin
          w.move_dir = mv_dir;
          if (mv_dir <= DirLeft) begin
            w.target_horiz = 10'(mv_tgt);
            w.measured_horiz = 10'(mv_meas);
          end else begin
            w.target_vert = 10'(mv_tgt);
            w.measured_vert = 10'(mv_meas);
          end
          w.now_ms = ms;
          w.move_begin_ms = mv_begin;
          ticks_left--;
        end else if (roll < 93) begin
          // Broken sequence: a stray direction or a stale start time within a move.
          odd_dir = 3'($urandom_range(DirNone, DirDown));
          w = tick_of(odd_dir, mv_tgt, mv_meas, mv_tgt, mv_meas, ms,
                      mv_begin - $urandom_range(0, 500));
        end else if (roll < 97) begin
          w.now_ms = ms;
          w.move_begin_ms = $urandom_range(0, ms);
        end
        send_tick(w);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_duties != 0);
    repeat (10) @(posedge clk);
    $display("Covered %0d control ticks over %0d gain settings, with and without idling;",
             ticks_sent, NumPhases + 1);
    $display("%0d duty words compared, %0d of them driving the motor.",
             duties_compared, active_duties);
    if (duty_mismatches == 0 && pending_duties == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
